### rtl/psc_pkg.sv
// shared types, constants and helpers for the pressure sensor compensation block
package psc_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned RAW_W    = 16;
	localparam int unsigned NUM_REGS = 5;
	localparam int unsigned PADDR_W  = 5;

	typedef enum logic [2:0] {
		REG_AC1_AC2 = 3'd0,
		REG_AC3_AC4 = 3'd1,
		REG_AC5_AC6 = 3'd2,
		REG_B1_B2   = 3'd3,
		REG_MC_MD   = 3'd4
	} reg_idx_t;

	typedef logic [NUM_REGS-1:0][DATA_W-1:0] cal_regs_t;

	localparam logic [DATA_W-1:0] K_B6_OFFSET = 32'd4000;
	localparam logic [DATA_W-1:0] K_B4_BIAS   = 32'd32768;
	localparam logic [DATA_W-1:0] K_B7_SCALE  = 32'd50000;
	localparam logic [DATA_W-1:0] K_P_SQ      = 32'd3038;
	// -7357 in two's complement
	localparam logic [DATA_W-1:0] K_P_LIN     = 32'hFFFF_E343;
	localparam logic [DATA_W-1:0] K_P_ROUND   = 32'd3791;

	// sideband that rides along with the temperature division
	typedef struct packed {
		logic [DATA_W-1:0] x1;
		logic [RAW_W-1:0]  up;
		logic              neg;
		logic              err;
	} tdiv_pay_t;

	// sideband that rides along with the pressure division
	typedef struct packed {
		logic [DATA_W-1:0] temp;
		logic              hi;
		logic              err;
	} pdiv_pay_t;

	function automatic logic [DATA_W-1:0] sx16(input logic [RAW_W-1:0] v);
		return {{(DATA_W-RAW_W){v[RAW_W-1]}}, v};
	endfunction

	function automatic logic [DATA_W-1:0] zx16(input logic [RAW_W-1:0] v);
		return {{(DATA_W-RAW_W){1'b0}}, v};
	endfunction

endpackage

### rtl/psc_regs.sv
// calibration register file behind the apb-style port
module psc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [psc_pkg::PADDR_W-1:0]    paddr,
	input  logic [psc_pkg::DATA_W-1:0]     pwdata,
	output logic [psc_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	output psc_pkg::cal_regs_t             cal
);

	psc_pkg::cal_regs_t cal_q;
	psc_pkg::reg_idx_t  idx;

	assign idx    = psc_pkg::reg_idx_t'(paddr[psc_pkg::PADDR_W-1:2]);
	assign pready = 1'b1;
	assign cal    = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				psc_pkg::REG_AC1_AC2: cal_q[psc_pkg::REG_AC1_AC2] <= pwdata;
				psc_pkg::REG_AC3_AC4: cal_q[psc_pkg::REG_AC3_AC4] <= pwdata;
				psc_pkg::REG_AC5_AC6: cal_q[psc_pkg::REG_AC5_AC6] <= pwdata;
				psc_pkg::REG_B1_B2:   cal_q[psc_pkg::REG_B1_B2]   <= pwdata;
				psc_pkg::REG_MC_MD:   cal_q[psc_pkg::REG_MC_MD]   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			psc_pkg::REG_AC1_AC2: prdata = cal_q[psc_pkg::REG_AC1_AC2];
			psc_pkg::REG_AC3_AC4: prdata = cal_q[psc_pkg::REG_AC3_AC4];
			psc_pkg::REG_AC5_AC6: prdata = cal_q[psc_pkg::REG_AC5_AC6];
			psc_pkg::REG_B1_B2:   prdata = cal_q[psc_pkg::REG_B1_B2];
			psc_pkg::REG_MC_MD:   prdata = cal_q[psc_pkg::REG_MC_MD];
			default:              prdata = '0;
		endcase
	end

endmodule

### rtl/psc_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module psc_div #(
	parameter int unsigned Width        = psc_pkg::DATA_W,
	parameter int unsigned PayloadWidth = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    src_valid,
	output logic                    src_ready,
	input  logic [Width-1:0]        src_num,
	input  logic [Width-1:0]        src_den,
	input  logic [PayloadWidth-1:0] src_payload,
	output logic                    dst_valid,
	input  logic                    dst_take,
	output logic [Width-1:0]        dst_quot,
	output logic [PayloadWidth-1:0] dst_payload
);

	logic [Width-1:0]        rem_q [Width];
	logic [Width-1:0]        num_q [Width];
	logic [Width-1:0]        den_q [Width];
	logic [PayloadWidth-1:0] pay_q [Width];
	logic [Width-1:0]        vld_q;
	logic [Width-1:0]        en;

	for (genvar k = 0; k < Width; k++) begin : g_stage
		logic [Width-1:0]        p_rem;
		logic [Width-1:0]        p_num;
		logic [Width-1:0]        p_den;
		logic [PayloadWidth-1:0] p_pay;
		logic                    p_vld;
		logic [Width:0]          trial;
		logic [Width:0]          diff;
		logic                    ge;

		if (k == 0) begin : g_first
			assign p_rem = '0;
			assign p_num = src_num;
			assign p_den = src_den;
			assign p_pay = src_payload;
			assign p_vld = src_valid;
		end else begin : g_next
			assign p_rem = rem_q[k-1];
			assign p_num = num_q[k-1];
			assign p_den = den_q[k-1];
			assign p_pay = pay_q[k-1];
			assign p_vld = vld_q[k-1];
		end

		if (k == Width - 1) begin : g_last_en
			assign en[k] = !vld_q[k] || dst_take;
		end else begin : g_mid_en
			assign en[k] = !vld_q[k] || en[k+1];
		end

		assign trial = {p_rem, p_num[Width-1]};
		assign diff  = trial - {1'b0, p_den};
		// no borrow out of the subtraction means the trial remainder covers the divisor
		assign ge    = !diff[Width];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en[k]) begin
				vld_q[k] <= p_vld;
			end
		end

		// quotient bits shift in from the right as numerator bits leave
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_q[k] <= ge ? diff[Width-1:0] : trial[Width-1:0];
				num_q[k] <= {p_num[Width-2:0], ge};
				den_q[k] <= p_den;
				pay_q[k] <= p_pay;
			end
		end
	end

	assign src_ready   = en[0];
	assign dst_valid   = vld_q[Width-1];
	assign dst_quot    = num_q[Width-1];
	assign dst_payload = pay_q[Width-1];

endmodule

### rtl/pressure_sensor_compensation.sv
// pressure sensor compensation top level: a transfer passes stages 1-2, the temperature divider, stages 3-8,
// the pressure divider and stages 9-12; throughput one reading pair per cycle while the receiver does not stall;
// two 32-stage dividers set the depth; each stage advances when empty or when the next stage moves, so bubbles
// absorb output stalls; reset clears all valid bits and the calibration registers to zero
module pressure_sensor_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [psc_pkg::PADDR_W-1:0]   paddr,
	input  logic [psc_pkg::DATA_W-1:0]    pwdata,
	output logic [psc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [psc_pkg::RAW_W-1:0]     raw_temperature,
	input  logic [psc_pkg::RAW_W-1:0]     raw_pressure,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [psc_pkg::DATA_W-1:0] temperature_tenths,
	output logic signed [psc_pkg::DATA_W-1:0] pressure_pa,
	output logic                          divide_error
);

	localparam int unsigned W  = psc_pkg::DATA_W;
	localparam int unsigned TP = $bits(psc_pkg::tdiv_pay_t);
	localparam int unsigned PP = $bits(psc_pkg::pdiv_pay_t);

	psc_pkg::cal_regs_t cal;

	psc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal     (cal)
	);

	logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = psc_pkg::sx16(cal[psc_pkg::REG_AC1_AC2][31:16]);
	assign ac2 = psc_pkg::sx16(cal[psc_pkg::REG_AC1_AC2][15:0]);
	assign ac3 = psc_pkg::sx16(cal[psc_pkg::REG_AC3_AC4][31:16]);
	assign ac4 = psc_pkg::zx16(cal[psc_pkg::REG_AC3_AC4][15:0]);
	assign ac5 = psc_pkg::zx16(cal[psc_pkg::REG_AC5_AC6][31:16]);
	assign ac6 = psc_pkg::zx16(cal[psc_pkg::REG_AC5_AC6][15:0]);
	assign b1  = psc_pkg::sx16(cal[psc_pkg::REG_B1_B2][31:16]);
	assign b2  = psc_pkg::sx16(cal[psc_pkg::REG_B1_B2][15:0]);
	assign mc  = psc_pkg::sx16(cal[psc_pkg::REG_MC_MD][31:16]);
	assign md  = psc_pkg::sx16(cal[psc_pkg::REG_MC_MD][15:0]);

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;
	logic en_s9, en_s10, en_s11, en_s12;
	logic tdiv_ready, tdiv_valid, pdiv_ready, pdiv_valid;

	assign en_s12 = !v_s12 || !result_stall;
	assign en_s11 = !v_s11 || en_s12;
	assign en_s10 = !v_s10 || en_s11;
	assign en_s9  = !v_s9  || en_s10;
	assign en_s8  = !v_s8  || pdiv_ready;
	assign en_s7  = !v_s7  || en_s8;
	assign en_s6  = !v_s6  || en_s7;
	assign en_s5  = !v_s5  || en_s6;
	assign en_s4  = !v_s4  || en_s5;
	assign en_s3  = !v_s3  || en_s4;
	assign en_s2  = !v_s2  || tdiv_ready;
	assign en_s1  = !v_s1  || en_s2;

	assign sample_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= sample_valid;
			if (en_s2)  v_s2  <= v_s1;
			if (en_s3)  v_s3  <= tdiv_valid;
			if (en_s4)  v_s4  <= v_s3;
			if (en_s5)  v_s5  <= v_s4;
			if (en_s6)  v_s6  <= v_s5;
			if (en_s7)  v_s7  <= v_s6;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= pdiv_valid;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
			if (en_s12) v_s12 <= v_s11;
		end
	end

	// stage 1: x1 = (ut - ac6) * ac5 >> 15
	logic [W-1:0] d1, m1;
	logic [W-1:0] x1_s1;
	logic [psc_pkg::RAW_W-1:0] up_s1;
	assign d1 = psc_pkg::zx16(raw_temperature) - ac6;
	assign m1 = d1 * ac5;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x1_s1 <= $signed(m1) >>> 15;
			up_s1 <= raw_pressure;
		end
	end

	// stage 2: signed operands of mc * 2048 / (x1 + md) turned to magnitudes
	logic [W-1:0] den2, num2;
	logic [W-1:0] an_s2, ad_s2;
	psc_pkg::tdiv_pay_t tpay_s2;
	assign den2 = x1_s1 + md;
	assign num2 = {mc[W-12:0], 11'd0};

	always_ff @(posedge clk) begin
		if (en_s2) begin
			an_s2       <= num2[W-1] ? W'(-num2) : num2;
			ad_s2       <= den2[W-1] ? W'(-den2) : den2;
			tpay_s2.x1  <= x1_s1;
			tpay_s2.up  <= up_s1;
			tpay_s2.neg <= num2[W-1] ^ den2[W-1];
			tpay_s2.err <= den2 == '0;
		end
	end

	logic [W-1:0]  tq;
	logic [TP-1:0] tpay_raw;
	psc_pkg::tdiv_pay_t tpay;
	assign tpay = psc_pkg::tdiv_pay_t'(tpay_raw);

	psc_div #(.Width(W), .PayloadWidth(TP)) u_tdiv (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (v_s2),
		.src_ready   (tdiv_ready),
		.src_num     (an_s2),
		.src_den     (ad_s2),
		.src_payload (TP'(tpay_s2)),
		.dst_valid   (tdiv_valid),
		.dst_take    (en_s3),
		.dst_quot    (tq),
		.dst_payload (tpay_raw)
	);

	// stage 3: b5 = x1 + x2
	logic [W-1:0] b5_s3;
	logic [psc_pkg::RAW_W-1:0] up_s3;
	logic err_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			b5_s3  <= tpay.x1 + (tpay.neg ? W'(-tq) : tq);
			up_s3  <= tpay.up;
			err_s3 <= tpay.err;
		end
	end

	// stage 4: temperature and b6
	logic [W-1:0] b5r4;
	logic [W-1:0] temp_s4, b6_s4;
	logic [psc_pkg::RAW_W-1:0] up_s4;
	logic err_s4;
	assign b5r4 = b5_s3 + W'(8);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			temp_s4 <= $signed(b5r4) >>> 4;
			b6_s4   <= b5_s3 - psc_pkg::K_B6_OFFSET;
			up_s4   <= up_s3;
			err_s4  <= err_s3;
		end
	end

	// stage 5: products on b6
	logic [W-1:0] sqm5, ac2m5, ac3m5;
	logic [W-1:0] sq_s5, x2_s5, x1c_s5, temp_s5;
	logic [psc_pkg::RAW_W-1:0] up_s5;
	logic err_s5;
	assign sqm5  = b6_s4 * b6_s4;
	assign ac2m5 = ac2 * b6_s4;
	assign ac3m5 = ac3 * b6_s4;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			sq_s5   <= $signed(sqm5) >>> 12;
			x2_s5   <= $signed(ac2m5) >>> 11;
			x1c_s5  <= $signed(ac3m5) >>> 13;
			temp_s5 <= temp_s4;
			up_s5   <= up_s4;
			err_s5  <= err_s4;
		end
	end

	// stage 6: products on the square term
	logic [W-1:0] b2m6, b1m6;
	logic [W-1:0] x1_s6, x2_s6, x1c_s6, x2c_s6, temp_s6;
	logic [psc_pkg::RAW_W-1:0] up_s6;
	logic err_s6;
	assign b2m6 = b2 * sq_s5;
	assign b1m6 = b1 * sq_s5;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			x1_s6   <= $signed(b2m6) >>> 11;
			x2c_s6  <= $signed(b1m6) >>> 16;
			x2_s6   <= x2_s5;
			x1c_s6  <= x1c_s5;
			temp_s6 <= temp_s5;
			up_s6   <= up_s5;
			err_s6  <= err_s5;
		end
	end

	// stage 7: b3 and x3
	logic [W-1:0] b3sum7, x3sum7;
	logic [W-1:0] b3_s7, x3_s7, temp_s7;
	logic [psc_pkg::RAW_W-1:0] up_s7;
	logic err_s7;
	assign b3sum7 = {ac1[W-3:0], 2'b00} + x1_s6 + x2_s6 + W'(2);
	assign x3sum7 = x1c_s6 + x2c_s6 + W'(2);

	always_ff @(posedge clk) begin
		if (en_s7) begin
			b3_s7   <= $signed(b3sum7) >>> 2;
			x3_s7   <= $signed(x3sum7) >>> 2;
			temp_s7 <= temp_s6;
			up_s7   <= up_s6;
			err_s7  <= err_s6;
		end
	end

	// stage 8: b4 and b7, numerator chosen by the top bit of b7
	logic [W-1:0] b4m8, b4_8, b7_8;
	logic [W-1:0] num_s8, b4_s8;
	psc_pkg::pdiv_pay_t ppay_s8;
	assign b4m8 = ac4 * (x3_s7 + psc_pkg::K_B4_BIAS);
	assign b4_8 = b4m8 >> 15;
	assign b7_8 = (psc_pkg::zx16(up_s7) - b3_s7) * psc_pkg::K_B7_SCALE;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			num_s8       <= b7_8[W-1] ? b7_8 : {b7_8[W-2:0], 1'b0};
			b4_s8        <= b4_8;
			ppay_s8.temp <= temp_s7;
			ppay_s8.hi   <= b7_8[W-1];
			ppay_s8.err  <= err_s7 || (b4_8 == '0);
		end
	end

	logic [W-1:0]  pq;
	logic [PP-1:0] ppay_raw;
	psc_pkg::pdiv_pay_t ppay;
	assign ppay = psc_pkg::pdiv_pay_t'(ppay_raw);

	psc_div #(.Width(W), .PayloadWidth(PP)) u_pdiv (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (v_s8),
		.src_ready   (pdiv_ready),
		.src_num     (num_s8),
		.src_den     (b4_s8),
		.src_payload (PP'(ppay_s8)),
		.dst_valid   (pdiv_valid),
		.dst_take    (en_s9),
		.dst_quot    (pq),
		.dst_payload (ppay_raw)
	);

	// stage 9: raw pressure, doubled after the division for large b7
	logic [W-1:0] p_s9, temp_s9;
	logic err_s9;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			p_s9    <= ppay.hi ? {pq[W-2:0], 1'b0} : pq;
			temp_s9 <= ppay.temp;
			err_s9  <= ppay.err;
		end
	end

	// stage 10: (p >> 8)^2 and the linear term
	logic [W-1:0] ps10, sqm10, linm10;
	logic [W-1:0] x1_s10, x2_s10, p_s10, temp_s10;
	logic err_s10;
	assign ps10   = $signed(p_s9) >>> 8;
	assign sqm10  = ps10 * ps10;
	assign linm10 = psc_pkg::K_P_LIN * p_s9;

	always_ff @(posedge clk) begin
		if (en_s10) begin
			x1_s10   <= sqm10;
			x2_s10   <= $signed(linm10) >>> 16;
			p_s10    <= p_s9;
			temp_s10 <= temp_s9;
			err_s10  <= err_s9;
		end
	end

	// stage 11: scale the square term
	logic [W-1:0] x1m11;
	logic [W-1:0] x1_s11, x2_s11, p_s11, temp_s11;
	logic err_s11;
	assign x1m11 = x1_s10 * psc_pkg::K_P_SQ;

	always_ff @(posedge clk) begin
		if (en_s11) begin
			x1_s11   <= $signed(x1m11) >>> 16;
			x2_s11   <= x2_s10;
			p_s11    <= p_s10;
			temp_s11 <= temp_s10;
			err_s11  <= err_s10;
		end
	end

	// stage 12: final correction into the output register
	logic [W-1:0] corr12, pf12;
	logic [W-1:0] temp_s12, pres_s12;
	logic err_s12;
	assign corr12 = x1_s11 + x2_s11 + psc_pkg::K_P_ROUND;
	assign pf12   = p_s11 + W'($signed(corr12) >>> 4);

	always_ff @(posedge clk) begin
		if (en_s12) begin
			temp_s12 <= err_s11 ? '0 : temp_s11;
			pres_s12 <= err_s11 ? '0 : pf12;
			err_s12  <= err_s11;
		end
	end

	assign result_valid       = v_s12;
	assign temperature_tenths = $signed(temp_s12);
	assign pressure_pa        = $signed(pres_s12);
	assign divide_error       = err_s12;

endmodule

### tb/testbench.sv
// self-checking testbench for the pressure sensor compensation block
module testbench;

	typedef struct {
		logic [31:0] temp;
		logic [31:0] pres;
		logic        err;
	} reading_t;

	logic                clk;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [psc_pkg::PADDR_W-1:0]  paddr;
	logic [psc_pkg::DATA_W-1:0]   pwdata;
	logic [psc_pkg::DATA_W-1:0]   prdata;
	logic                pready;
	logic                sample_valid;
	logic                sample_stall;
	logic [psc_pkg::RAW_W-1:0]    raw_temperature, raw_pressure;
	logic                result_valid;
	logic                result_stall;
	logic signed [psc_pkg::DATA_W-1:0] temperature_tenths, pressure_pa;
	logic                divide_error;

	logic [31:0] cal [psc_pkg::NUM_REGS];
	reading_t    expected_q[$];
	int          fail_count = 0;
	int unsigned cycle_count = 0;
	bit          stall_mode = 0;

	pressure_sensor_compensation u_dut (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("pressure_sensor_compensation test failed");
			$finish;
		end
	end

	function automatic logic [31:0] asr(input logic [31:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [31:0] sext(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] quot_s(input logic [31:0] n, input logic [31:0] d);
		longint q;
		q = longint'($signed(n)) / longint'($signed(d));
		return q[31:0];
	endfunction

	function automatic reading_t compensate(input logic [15:0] ut, input logic [15:0] up);
		reading_t r;
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t, den;
		ac1 = sext(cal[psc_pkg::REG_AC1_AC2][31:16]);
		ac2 = sext(cal[psc_pkg::REG_AC1_AC2][15:0]);
		ac3 = sext(cal[psc_pkg::REG_AC3_AC4][31:16]);
		ac4 = {16'd0, cal[psc_pkg::REG_AC3_AC4][15:0]};
		ac5 = {16'd0, cal[psc_pkg::REG_AC5_AC6][31:16]};
		ac6 = {16'd0, cal[psc_pkg::REG_AC5_AC6][15:0]};
		b1 = sext(cal[psc_pkg::REG_B1_B2][31:16]); b2 = sext(cal[psc_pkg::REG_B1_B2][15:0]);
		mc = sext(cal[psc_pkg::REG_MC_MD][31:16]); md = sext(cal[psc_pkg::REG_MC_MD][15:0]);
		r = '{32'd0, 32'd0, 1'b1};
		x1 = asr(({16'd0, ut} - ac6) * ac5, 15);
		den = x1 + md;
		if (den == 0) return r;
		x2 = quot_s(mc * 32'd2048, den);
		b5 = x1 + x2;
		t = asr(b5 + 32'd8, 4);
		b6 = b5 - 32'd4000;
		sq = asr(b6 * b6, 12);
		x1 = asr(b2 * sq, 11);
		x2 = asr(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = asr(ac1 * 32'd4 + x3 + 32'd2, 2);
		x1 = asr(ac3 * b6, 13);
		x2 = asr(b1 * sq, 16);
		x3 = asr(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		if (b4 == 0) return r;
		b7 = ({16'd0, up} - b3) * 32'd50000;
		if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
		else p = (b7 / b4) * 32'd2;
		x1 = asr(p, 8) * asr(p, 8);
		x1 = asr(x1 * 32'd3038, 16);
		x2 = asr(32'hFFFF_E343 * p, 16);
		p = p + asr(x1 + x2 + 32'd3791, 4);
		r = '{t, p, 1'b0};
		return r;
	endfunction

	// setup and access phase; the caller releases the bus after its last write
	task automatic write_cal(input psc_pkg::reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= psc_pkg::PADDR_W'(4 * idx); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cal[idx] = val;
	endtask

	task automatic drain;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic load_cal(input logic [31:0] v0, v1, v2, v3, v4);
		drain();
		write_cal(psc_pkg::REG_AC1_AC2, v0);
		write_cal(psc_pkg::REG_AC3_AC4, v1);
		write_cal(psc_pkg::REG_AC5_AC6, v2);
		write_cal(psc_pkg::REG_B1_B2, v3);
		write_cal(psc_pkg::REG_MC_MD, v4);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// one transfer; valid held across back-to-back items
	task automatic send_reading(input logic [15:0] ut, input logic [15:0] up,
			input bit keep_valid);
		sample_valid <= 1'b1;
		raw_temperature <= ut;
		raw_pressure <= up;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		expected_q.push_back(compensate(ut, up));
		if (!keep_valid) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_burst(input int n, input bit typical);
		int left, len;
		logic [15:0] ut, up;
		left = n;
		while (left > 0) begin
			len = $urandom_range(1, 20);
			if (len > left) len = left;
			for (int i = 0; i < len; i++) begin
				if (typical) begin
					ut = 16'($urandom_range(20000, 35000));
					up = 16'($urandom_range(20000, 45000));
				end else begin
					ut = 16'($urandom); up = 16'($urandom);
				end
				send_reading(ut, up, i != len - 1);
			end
			left -= len;
			if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h %h %b", $time,
					temperature_tenths, pressure_pa, divide_error);
				fail_count++;
			end else begin
				reading_t e;
				e = expected_q.pop_front();
				if (temperature_tenths !== e.temp) begin
					$display("%0t: temperature expected %0d actual %0d", $time,
						$signed(e.temp), temperature_tenths);
					fail_count++;
				end
				if (pressure_pa !== e.pres) begin
					$display("%0t: pressure expected %0d actual %0d", $time,
						$signed(e.pres), pressure_pa);
					fail_count++;
				end
				if (divide_error !== e.err) begin
					$display("%0t: divide_error expected %b actual %b", $time,
						e.err, divide_error);
					fail_count++;
				end
			end
		end
	end

	// receiver stall pattern, switched between calm and busy stretches
	always @(posedge clk) begin
		if (!arst_n) result_stall <= 1'b0;
		else if (stall_mode) result_stall <= ($urandom_range(0, 2) == 0);
		else result_stall <= 1'b0;
		if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
	end

	task automatic test_reset_regs;
		// all-zero calibration: divisor zero
		send_reading(16'h0000, 16'h0000, 0);
		send_reading(16'hFFFF, 16'hFFFF, 0);
	endtask

	task automatic test_typical;
		load_cal(32'h01D8_FFBE, 32'hC7AA_7F9A, 32'h61D5_4A1B, 32'h1978_0022,
			32'hD4BD_0AE0);
		send_reading(16'd27898, 16'd23843, 0);
		send_reading(16'h0000, 16'h0000, 1);
		send_reading(16'hFFFF, 16'hFFFF, 1);
		send_reading(16'h0000, 16'hFFFF, 1);
		send_reading(16'hFFFF, 16'h0000, 0);
		send_reading(16'h5555, 16'hAAAA, 0);
		send_reading(16'hAAAA, 16'h5555, 0);
		send_burst(700, 1);
		// pause until all results are in
		drain();
		send_burst(100, 0);
	endtask

	task automatic test_temp_divisor_zero;
		// ac5=0 gives x1=0; md=0 gives zero divisor
		load_cal(32'h01D8_FFBE, 32'hC7AA_7F9A, 32'h0000_4A1B, 32'h1978_0022,
			32'hD4BD_0000);
		send_reading(16'd27898, 16'd23843, 0);
		send_reading(16'hFFFF, 16'h1234, 0);
	endtask

	task automatic test_pres_divisor_zero;
		// ac4=0 forces b4 to zero
		load_cal(32'h01D8_FFBE, 32'hC7AA_0000, 32'h61D5_4A1B, 32'h1978_0022,
			32'hD4BD_0AE0);
		send_reading(16'd27898, 16'd23843, 0);
		send_reading(16'h0001, 16'hFFFE, 0);
	endtask

	task automatic test_extremes;
		load_cal(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_FFFF, 32'h7FFF_8000,
			32'h8000_7FFF);
		send_reading(16'h0000, 16'hFFFF, 0);
		send_reading(16'hFFFF, 16'h0000, 0);
		send_burst(200, 0);
		load_cal(32'h8000_7FFF, 32'h7FFF_0001, 32'h0001_0001, 32'h8000_7FFF,
			32'h7FFF_8000);
		send_burst(200, 0);
	endtask

	task automatic test_random_cal;
		for (int k = 0; k < 6; k++) begin
			load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
			send_burst(100, 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		sample_valid = 0; raw_temperature = '0; raw_pressure = '0;
		for (int i = 0; i < psc_pkg::NUM_REGS; i++) cal[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_regs();
		test_typical();
		test_temp_divisor_zero();
		test_pres_divisor_zero();
		test_extremes();
		test_random_cal();
		drain();
		if (fail_count == 0 && expected_q.size() == 0)
			$display("pressure_sensor_compensation test passed");
		else
			$display("pressure_sensor_compensation test failed");
		$finish;
	end

endmodule
